// ===== design/cjps_pkg.sv =====
package cjps_pkg;

   typedef struct packed {
      logic signed [31:0] knot_offset;
      logic signed [31:0] knot_slope;
      logic signed [31:0] knot_curv_term;
      logic               final_knot;
   } cjps_req_type;

   typedef struct packed {
      logic signed [31:0] station;
      logic signed [31:0] offset;
      logic signed [31:0] slope;
      logic signed [31:0] second_deriv;
      logic signed [31:0] curvature;
      logic               last_point;
   } cjps_rsp_type;

   // request to the curvature unit: u = 1 + dl^2, magnitude and sign of ddl
   typedef struct packed {
      logic        start;
      logic        neg;
      logic [47:0] u;
      logic [31:0] mag;
   } cjps_curv_req_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] value;
   } cjps_curv_rsp_type;

   localparam logic [1:0] REG_SPACING  = 2'd0;
   localparam logic [1:0] REG_INV      = 2'd1;
   localparam logic [1:0] REG_STEP     = 2'd2;
   localparam logic [1:0] REG_POINTS   = 2'd3;

   localparam logic signed [32:0] ONE_SIXTH_Q16 = 33'sd10923;
   localparam logic [47:0]        U_ONE         = 48'd65536;

   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      logic signed [31:0] r;
      if (v > 68'sh0_0000_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -68'sh0_0000_0000_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [67:0] sx68(input logic signed [31:0] v);
      return {{36{v[31]}}, v};
   endfunction

endpackage

// ===== design/cjps_mul.sv =====
module cjps_mul (
   input  logic               clock,
   input  logic signed [32:0] a,
   input  logic signed [32:0] b,
   output logic signed [65:0] prod_ff
);

   logic signed [65:0] prod_in;

   assign prod_in = a * b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== design/cjps_curv.sv =====
module cjps_curv (
   input  logic                        clock,
   input  logic                        reset,
   input  cjps_pkg::cjps_curv_req_type req,
   output cjps_pkg::cjps_curv_rsp_type rsp
);

   typedef enum logic [3:0] {
      C_IDLE = 4'b0001,
      C_SQRT = 4'b0010,
      C_DIV1 = 4'b0100,
      C_DIV2 = 4'b1000
   } cstate_type;

   cstate_type         state_ff, state_in;
   logic [63:0]        x_ff, x_in, r_ff, r_in, bit_ff, bit_in;
   logic [63:0]        rem_ff, rem_in, quo_ff, quo_in, dvd_ff, dvd_in, dvs_ff, dvs_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [47:0]        u_ff, u_in;
   logic [31:0]        mag_ff, mag_in;
   logic               neg_ff, neg_in, done_ff, done_in;
   logic signed [31:0] value_ff, value_in;

   logic [63:0]        rb, r_nx, rem2, quo_nx;
   logic               ge_s, ge_d;
   logic signed [67:0] kv;

   always_comb begin
      rb     = r_ff + bit_ff;
      ge_s   = x_ff >= rb;
      r_nx   = ge_s ? ((r_ff >> 1) + bit_ff) : (r_ff >> 1);
      rem2   = {rem_ff[62:0], dvd_ff[63]};
      ge_d   = rem2 >= dvs_ff;
      quo_nx = {quo_ff[62:0], ge_d};
      kv     = $signed({4'b0, quo_nx});

      state_in = state_ff;
      x_in     = x_ff;
      r_in     = r_ff;
      bit_in   = bit_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvd_in   = dvd_ff;
      dvs_in   = dvs_ff;
      cnt_in   = cnt_ff;
      u_in     = u_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;
      value_in = value_ff;

      case (state_ff)
         C_IDLE: begin
            if (req.start) begin
               x_in     = {req.u, 16'b0};
               r_in     = '0;
               bit_in   = 64'h4000_0000_0000_0000;
               u_in     = req.u;
               mag_in   = req.mag;
               neg_in   = req.neg;
               state_in = C_SQRT;
            end
         end
         C_SQRT: begin
            x_in   = ge_s ? (x_ff - rb) : x_ff;
            r_in   = r_nx;
            bit_in = bit_ff >> 2;
            if (bit_ff == 64'd1) begin
               dvd_in   = {mag_ff, 32'b0};
               dvs_in   = {16'b0, u_ff};
               rem_in   = '0;
               quo_in   = '0;
               cnt_in   = '0;
               state_in = C_DIV1;
            end
         end
         C_DIV1: begin
            rem_in = ge_d ? (rem2 - dvs_ff) : rem2;
            quo_in = quo_nx;
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               dvd_in   = quo_nx;
               dvs_in   = r_ff;
               rem_in   = '0;
               quo_in   = '0;
               cnt_in   = '0;
               state_in = C_DIV2;
            end
         end
         C_DIV2: begin
            rem_in = ge_d ? (rem2 - dvs_ff) : rem2;
            quo_in = quo_nx;
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               value_in = cjps_pkg::sat32(neg_ff ? -kv : kv);
               done_in  = 1'b1;
               state_in = C_IDLE;
            end
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      x_ff     <= x_in;
      r_ff     <= r_in;
      bit_ff   <= bit_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvd_ff   <= dvd_in;
      dvs_ff   <= dvs_in;
      cnt_ff   <= cnt_in;
      u_ff     <= u_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      value_ff <= value_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.value = value_ff;

endmodule

// ===== design/constant_jerk_path_sampler.sv =====
// Constant-jerk path sampler.
// Knots enter on the req_ channel (valid/stall); samples leave on the rsp_ channel.
// Registers (spacing, reciprocal, step, points per fragment) sit behind an APB
// port at byte addresses 0, 4, 8 and 12; write them only while the block is idle.
// The first knot of a path is stored and yields no sample unless it is final.
// Each later knot yields the previous knot plus points_per_fragment-2 Taylor
// samples, and the final knot also yields itself with last_point set.
// For every sample, the dl^2 product is formed on the shared multiplier, the
// bit-serial curvature unit takes the square root and the two divisions, the
// result is taken back and the output register is loaded.
// Each Taylor step puts seven products through the one registered multiplier;
// a knot first puts its setup products (h^2, h^3, jerk) through it.
// A knot holds the input until its fragment is done, and when it is final until
// its own sample is done too; a first knot that is not final is taken with no
// hold at all.
// req_stall is high whenever a knot is in progress.
// If the receiver stalls, the finished sample waits in the output register and
// the sequencer holds until that register frees.
// Synchronous reset clears the path state and restores register defaults.
module constant_jerk_path_sampler #(
   parameter int MAX_POINTS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  cjps_pkg::cjps_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output cjps_pkg::cjps_rsp_type rsp_data,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [3:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   localparam int         CW   = $clog2(MAX_POINTS + 1);
   localparam logic [6:0] MAXP = 7'(MAX_POINTS);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_PRE   = 6'b000010,
      S_CURV  = 6'b000100,
      S_CWAIT = 6'b001000,
      S_EMIT  = 6'b010000,
      S_STEP  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      ph_ff, ph_in;
   logic [2:0] op_ff, op_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   logic [30:0] spacing_ff, spacing_in, inv_ff, inv_in, step_ff, step_in;
   logic [5:0]  points_ff, points_in;

   logic               have_prev_ff, have_prev_in;
   logic signed [31:0] base_ff, base_in;
   logic signed [31:0] prev_l_ff, prev_l_in, prev_dl_ff, prev_dl_in, prev_ddl_ff, prev_ddl_in;
   cjps_pkg::cjps_req_type knot_ff, knot_in;
   logic signed [31:0] h2_ff, h2_in, h3_ff, h3_in, jerk_ff, jerk_in;
   logic signed [31:0] p_ff [7];
   logic signed [31:0] p_in [7];
   logic signed [31:0] cur_s_ff, cur_s_in, cur_l_ff, cur_l_in;
   logic signed [31:0] cur_dl_ff, cur_dl_in, cur_ddl_ff, cur_ddl_in, cur_k_ff, cur_k_in;
   logic               cur_last_ff, cur_last_in;
   cjps_pkg::cjps_rsp_type rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic signed [32:0] mul_a, mul_b;
   logic               mul_sh17;
   logic signed [65:0] prod, q;
   logic signed [31:0] mq;
   logic signed [32:0] h33, dlx, dl_mag, ddx, ddl_mag, diff;
   logic [6:0]         pts7;
   logic [CW-1:0]      ppf;
   logic               out_free, cfg_wr;
   logic signed [31:0] base_next;
   cjps_pkg::cjps_curv_req_type curv_req;
   cjps_pkg::cjps_curv_rsp_type curv_rsp;

   cjps_mul u_mul (
      .clock   (clock),
      .a       (mul_a),
      .b       (mul_b),
      .prod_ff (prod)
   );

   cjps_curv u_curv (
      .clock (clock),
      .reset (reset),
      .req   (curv_req),
      .rsp   (curv_rsp)
   );

   // configuration port
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_comb begin
      case (paddr[3:2])
         cjps_pkg::REG_SPACING: prdata = {1'b0, spacing_ff};
         cjps_pkg::REG_INV:     prdata = {1'b0, inv_ff};
         cjps_pkg::REG_STEP:    prdata = {1'b0, step_ff};
         cjps_pkg::REG_POINTS:  prdata = {26'b0, points_ff};
         default:               prdata = '0;
      endcase
   end

   // clamp the fragment length to [2, MAX_POINTS]
   always_comb begin
      pts7 = {1'b0, points_ff};
      if (pts7 < 7'd2) begin
         ppf = CW'(2);
      end else if (pts7 > MAXP) begin
         ppf = CW'(MAX_POINTS);
      end else begin
         ppf = CW'(pts7);
      end
   end

   assign h33     = {2'b0, step_ff};
   assign dlx     = {cur_dl_ff[31], cur_dl_ff};
   assign dl_mag  = dlx[32] ? -dlx : dlx;
   assign ddx     = {cur_ddl_ff[31], cur_ddl_ff};
   assign ddl_mag = ddx[32] ? -ddx : ddx;
   assign diff    = {knot_ff.knot_curv_term[31], knot_ff.knot_curv_term}
                  - {prev_ddl_ff[31], prev_ddl_ff};

   // operand selection for the shared multiplier
   always_comb begin
      mul_a    = h33;
      mul_b    = h33;
      mul_sh17 = 1'b0;
      if (state_ff == S_PRE) begin
         case (op_ff)
            3'd0:    begin mul_a = h33; mul_b = h33; end
            3'd1:    begin mul_a = {h2_ff[31], h2_ff}; mul_b = h33; end
            default: begin mul_a = diff; mul_b = {2'b0, inv_ff}; end
         endcase
      end else if (state_ff == S_CURV) begin
         mul_a = dl_mag;
         mul_b = dl_mag;
      end else if (state_ff == S_STEP) begin
         case (op_ff)
            3'd0: begin mul_a = dlx; mul_b = h33; end
            3'd1: begin mul_a = ddx; mul_b = {h2_ff[31], h2_ff}; mul_sh17 = 1'b1; end
            3'd2: begin mul_a = {jerk_ff[31], jerk_ff}; mul_b = {h3_ff[31], h3_ff}; end
            3'd3: begin mul_a = {p_ff[2][31], p_ff[2]}; mul_b = cjps_pkg::ONE_SIXTH_Q16; end
            3'd4: begin mul_a = ddx; mul_b = h33; end
            3'd5: begin
               mul_a    = {jerk_ff[31], jerk_ff};
               mul_b    = {h2_ff[31], h2_ff};
               mul_sh17 = 1'b1;
            end
            default: begin mul_a = {jerk_ff[31], jerk_ff}; mul_b = h33; end
         endcase
      end
   end

   // floor shift of the registered product, then saturate
   always_comb begin
      q  = mul_sh17 ? (prod >>> 17) : (prod >>> 16);
      mq = cjps_pkg::sat32({{2{q[65]}}, q});
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign base_next = cjps_pkg::sat32(cjps_pkg::sx68(base_ff)
                                      + 68'(spacing_ff));

   always_comb begin
      state_in     = state_ff;
      ph_in        = ph_ff;
      op_in        = op_ff;
      cnt_in       = cnt_ff;
      spacing_in   = spacing_ff;
      inv_in       = inv_ff;
      step_in      = step_ff;
      points_in    = points_ff;
      have_prev_in = have_prev_ff;
      base_in      = base_ff;
      prev_l_in    = prev_l_ff;
      prev_dl_in   = prev_dl_ff;
      prev_ddl_in  = prev_ddl_ff;
      knot_in      = knot_ff;
      h2_in        = h2_ff;
      h3_in        = h3_ff;
      jerk_in      = jerk_ff;
      p_in         = p_ff;
      cur_s_in     = cur_s_ff;
      cur_l_in     = cur_l_ff;
      cur_dl_in    = cur_dl_ff;
      cur_ddl_in   = cur_ddl_ff;
      cur_k_in     = cur_k_ff;
      cur_last_in  = cur_last_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      curv_req.start = 1'b0;
      curv_req.neg   = ddx[32];
      curv_req.u     = cjps_pkg::U_ONE + prod[63:16];
      curv_req.mag   = ddl_mag[31:0];

      if (cfg_wr) begin
         case (paddr[3:2])
            cjps_pkg::REG_SPACING: spacing_in = pwdata[30:0];
            cjps_pkg::REG_INV:     inv_in     = pwdata[30:0];
            cjps_pkg::REG_STEP:    step_in    = pwdata[30:0];
            cjps_pkg::REG_POINTS:  points_in  = pwdata[5:0];
            default:               points_in  = points_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               knot_in = req_data;
               ph_in   = 1'b0;
               op_in   = '0;
               if (!have_prev_ff) begin
                  // first knot: store it, emit only when it is also final
                  prev_l_in    = req_data.knot_offset;
                  prev_dl_in   = req_data.knot_slope;
                  prev_ddl_in  = req_data.knot_curv_term;
                  base_in      = '0;
                  have_prev_in = 1'b1;
                  if (req_data.final_knot) begin
                     cur_s_in    = '0;
                     cur_l_in    = req_data.knot_offset;
                     cur_dl_in   = req_data.knot_slope;
                     cur_ddl_in  = req_data.knot_curv_term;
                     cur_last_in = 1'b1;
                     state_in    = S_CURV;
                  end
               end else begin
                  state_in = S_PRE;
               end
            end
         end
         S_PRE: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               op_in = op_ff + 3'd1;
               case (op_ff)
                  3'd0:    h2_in   = mq;
                  3'd1:    h3_in   = mq;
                  default: jerk_in = mq;
               endcase
               if (op_ff == 3'd2) begin
                  // start the fragment at the previous knot
                  cur_s_in    = base_ff;
                  cur_l_in    = prev_l_ff;
                  cur_dl_in   = prev_dl_ff;
                  cur_ddl_in  = prev_ddl_ff;
                  cur_last_in = 1'b0;
                  cnt_in      = CW'(1);
                  op_in       = '0;
                  state_in    = S_CURV;
               end
            end
         end
         S_CURV: begin
            // dl^2 on the multiplier, then hand u to the curvature unit
            ph_in = !ph_ff;
            if (ph_ff) begin
               curv_req.start = 1'b1;
               state_in       = S_CWAIT;
            end
         end
         S_CWAIT: begin
            if (curv_rsp.done) begin
               cur_k_in = curv_rsp.value;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.station      = cur_s_ff;
               rsp_in.offset       = cur_l_ff;
               rsp_in.slope        = cur_dl_ff;
               rsp_in.second_deriv = cur_ddl_ff;
               rsp_in.curvature    = cur_k_ff;
               rsp_in.last_point   = cur_last_ff;
               ph_in               = 1'b0;
               op_in               = '0;
               if (cur_last_ff) begin
                  // end of path
                  have_prev_in = 1'b0;
                  base_in      = '0;
                  state_in     = S_IDLE;
               end else if (cnt_ff < (ppf - CW'(1))) begin
                  state_in = S_STEP;
               end else begin
                  // fragment done: advance the knot
                  base_in     = base_next;
                  prev_l_in   = knot_ff.knot_offset;
                  prev_dl_in  = knot_ff.knot_slope;
                  prev_ddl_in = knot_ff.knot_curv_term;
                  if (knot_ff.final_knot) begin
                     cur_s_in    = base_next;
                     cur_l_in    = knot_ff.knot_offset;
                     cur_dl_in   = knot_ff.knot_slope;
                     cur_ddl_in  = knot_ff.knot_curv_term;
                     cur_last_in = 1'b1;
                     state_in    = S_CURV;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         S_STEP: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               p_in[op_ff] = mq;
               op_in       = op_ff + 3'd1;
               if (op_ff == 3'd6) begin
                  // all products in: update from the old point
                  cur_l_in   = cjps_pkg::sat32(cjps_pkg::sx68(cur_l_ff)
                                + cjps_pkg::sx68(p_ff[0]) + cjps_pkg::sx68(p_ff[1])
                                + cjps_pkg::sx68(p_ff[3]));
                  cur_dl_in  = cjps_pkg::sat32(cjps_pkg::sx68(cur_dl_ff)
                                + cjps_pkg::sx68(p_ff[4]) + cjps_pkg::sx68(p_ff[5]));
                  cur_ddl_in = cjps_pkg::sat32(cjps_pkg::sx68(cur_ddl_ff)
                                + cjps_pkg::sx68(mq));
                  cur_s_in   = cjps_pkg::sat32(cjps_pkg::sx68(cur_s_ff) + 68'(step_ff));
                  cnt_in     = cnt_ff + CW'(1);
                  op_in      = '0;
                  state_in   = S_CURV;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ph_ff        <= 1'b0;
         op_ff        <= '0;
         cnt_ff       <= '0;
         spacing_ff   <= 31'd65536;
         inv_ff       <= 31'd65536;
         step_ff      <= 31'd16384;
         points_ff    <= 6'd5;
         have_prev_ff <= 1'b0;
         base_ff      <= '0;
         prev_l_ff    <= '0;
         prev_dl_ff   <= '0;
         prev_ddl_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ph_ff        <= ph_in;
         op_ff        <= op_in;
         cnt_ff       <= cnt_in;
         spacing_ff   <= spacing_in;
         inv_ff       <= inv_in;
         step_ff      <= step_in;
         points_ff    <= points_in;
         have_prev_ff <= have_prev_in;
         base_ff      <= base_in;
         prev_l_ff    <= prev_l_in;
         prev_dl_ff   <= prev_dl_in;
         prev_ddl_ff  <= prev_ddl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      knot_ff     <= knot_in;
      h2_ff       <= h2_in;
      h3_ff       <= h3_in;
      jerk_ff     <= jerk_in;
      p_ff        <= p_in;
      cur_s_ff    <= cur_s_in;
      cur_l_ff    <= cur_l_in;
      cur_dl_ff   <= cur_dl_in;
      cur_ddl_ff  <= cur_ddl_in;
      cur_k_ff    <= cur_k_in;
      cur_last_ff <= cur_last_in;
      rsp_ff      <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("sample not loaded into free output register");

   a_curv_done_wait: assert property (@(posedge clock) disable iff (reset)
      curv_rsp.done |-> (state_ff == S_CWAIT))
      else $error("curvature result outside wait state");

   a_base_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !have_prev_ff) |-> (base_ff == 32'sd0))
      else $error("station base not cleared between paths");

endmodule
